/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the partial register ALU executor.
// Macros expect clk in the including scope; PRA_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is held
`define PRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset
`define PRA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/pra_pkg.sv */
// Shared types and codes for the partial register ALU executor.
// No dependencies; imported by every module of the block.
package pra_pkg;

  // Request type codes
  localparam logic [2:0] REQ_MOV  = 3'd0;
  localparam logic [2:0] REQ_ADD  = 3'd1;
  localparam logic [2:0] REQ_SUB  = 3'd2;
  localparam logic [2:0] REQ_SHOW = 3'd3;

  // Operand selector codes
  localparam logic [3:0] SEL_EAX  = 4'd0;
  localparam logic [3:0] SEL_EDX  = 4'd2;
  localparam logic [3:0] SEL_AX   = 4'd3;
  localparam logic [3:0] SEL_DX   = 4'd5;
  localparam logic [3:0] SEL_AL   = 4'd6;
  localparam logic [3:0] SEL_DH   = 4'd11;
  localparam logic [3:0] SEL_EIP  = 4'd12;
  localparam logic [3:0] SEL_IMM  = 4'd14;

  localparam int unsigned DATA_W = 32;

  // Access width of a register selector
  typedef enum logic [1:0] {
    W_DWORD,
    W_WORD,
    W_BYTE
  } width_t;

  // ALU operation
  typedef enum logic [1:0] {
    ALU_MOV,
    ALU_ADD,
    ALU_SUB
  } alu_t;

  // Source of a show result
  typedef enum logic [1:0] {
    SHOW_REG,
    SHOW_EIP,
    SHOW_IMM
  } show_t;

  // Decoded request, handed from decode to execute
  typedef struct packed {
    logic   wr_en;     // valid mov/add/sub
    logic   show_en;   // valid show, produces a result
    alu_t   alu;
    show_t  show_kind;
    logic [1:0] dst_reg;
    width_t dst_w;
    logic   dst_hi;
    logic   src_imm;
    logic [1:0] src_reg;
    width_t src_w;
    logic   src_hi;
  } dec_t;

endpackage

/* hdl/pra_decode.sv */
// Request decoder: turns type and operand selectors into a dec_t.
// Depends on pra_pkg.
module pra_decode
  import pra_pkg::*;
(
  input  logic [2:0] req_type,
  input  logic [3:0] first_operand,
  input  logic [3:0] second_operand,
  output dec_t       dec
);

  typedef struct packed {
    logic       ok;
    logic [1:0] rsel;
    width_t     w;
    logic       hi;
  } sel_t;

  // Register selector -> register, width, byte lane
  function automatic sel_t sel_decode(input logic [3:0] sel);
    sel_t       s;
    logic [3:0] k;
    s = '{ok: 1'b0, rsel: 2'd0, w: W_DWORD, hi: 1'b0};
    k = 4'd0;
    if (sel <= SEL_EDX) begin
      s.ok   = 1'b1;
      s.rsel = sel[1:0];
    end else if (sel <= SEL_DX) begin
      k      = sel - SEL_AX;
      s.ok   = 1'b1;
      s.rsel = k[1:0];
      s.w    = W_WORD;
    end else if (sel <= SEL_DH) begin
      k      = sel - SEL_AL;
      s.ok   = 1'b1;
      s.rsel = k[2:1];
      s.w    = W_BYTE;
      s.hi   = k[0];
    end
    return s;
  endfunction

  sel_t s1, s2;
  logic src_ok;

  assign s1     = sel_decode(first_operand);
  assign s2     = sel_decode(second_operand);
  assign src_ok = s2.ok || (second_operand == SEL_IMM);

  always_comb begin
    dec.dst_reg = s1.rsel;
    dec.dst_w   = s1.w;
    dec.dst_hi  = s1.hi;
    dec.src_imm = !s2.ok;
    dec.src_reg = s2.rsel;
    dec.src_w   = s2.w;
    dec.src_hi  = s2.hi;

    // show: register, counter or immediate; anything else is dropped
    dec.show_en = (req_type == REQ_SHOW) &&
                  (s1.ok || first_operand == SEL_EIP || first_operand == SEL_IMM);
    if (s1.ok) begin
      dec.show_kind = SHOW_REG;
    end else if (first_operand == SEL_EIP) begin
      dec.show_kind = SHOW_EIP;
    end else begin
      dec.show_kind = SHOW_IMM;
    end

    // arithmetic needs a register destination and a usable source
    dec.wr_en = 1'b0;
    dec.alu   = ALU_MOV;
    case (req_type)
      REQ_MOV: begin
        dec.wr_en = s1.ok && src_ok;
        dec.alu   = ALU_MOV;
      end
      REQ_ADD: begin
        dec.wr_en = s1.ok && src_ok;
        dec.alu   = ALU_ADD;
      end
      REQ_SUB: begin
        dec.wr_en = s1.ok && src_ok;
        dec.alu   = ALU_SUB;
      end
      default: begin
        dec.wr_en = 1'b0;
        dec.alu   = ALU_MOV;
      end
    endcase
  end

endmodule

/* hdl/pra_exec.sv */
// Register file (three accumulators, instruction counter) and the ALU.
// Depends on pra_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pra_exec
  import pra_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,        // staged request executes this cycle
  input  dec_t              dec,
  input  logic [DATA_W-1:0] imm,
  output logic [DATA_W-1:0] show_value
);

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 16;

  logic [DATA_W-1:0] acc_a_r, acc_c_r, acc_d_r, instr_cnt_r;
  logic [DATA_W-1:0] acc_a_nxt, acc_c_nxt, acc_d_nxt, instr_cnt_nxt;
  logic [DATA_W-1:0] dst_word, src_word, dst_val, src_val, res, wmask, merged;

  function automatic logic [DATA_W-1:0] reg_pick(input logic [1:0] rsel,
                                                 input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] c,
                                                 input logic [DATA_W-1:0] d);
    logic [DATA_W-1:0] v;
    case (rsel)
      2'd0:    v = a;
      2'd1:    v = c;
      default: v = d;
    endcase
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] lane_mask(input width_t w);
    logic [DATA_W-1:0] m;
    case (w)
      W_WORD:  m = {{(DATA_W-WORD_W){1'b0}}, {WORD_W{1'b1}}};
      W_BYTE:  m = {{(DATA_W-BYTE_W){1'b0}}, {BYTE_W{1'b1}}};
      default: m = {DATA_W{1'b1}};
    endcase
    return m;
  endfunction

  // Extract the addressed bits, zero-extended
  function automatic logic [DATA_W-1:0] lane_read(input logic [DATA_W-1:0] word,
                                                  input width_t w,
                                                  input logic hi);
    logic [DATA_W-1:0] sh;
    sh = hi ? (word >> BYTE_W) : word;
    return sh & lane_mask(w);
  endfunction

  // Operand reads
  assign dst_word = reg_pick(dec.dst_reg, acc_a_r, acc_c_r, acc_d_r);
  assign src_word = reg_pick(dec.src_reg, acc_a_r, acc_c_r, acc_d_r);
  assign dst_val  = lane_read(dst_word, dec.dst_w, dec.dst_hi);
  assign src_val  = dec.src_imm ? imm : lane_read(src_word, dec.src_w, dec.src_hi);

  // ALU; truncation to the lane happens in the merge
  always_comb begin
    case (dec.alu)
      ALU_ADD: res = dst_val + src_val;
      ALU_SUB: res = dst_val - src_val;
      default: res = src_val;
    endcase
  end

  // Merge result into the addressed lane only
  assign wmask  = dec.dst_hi ? (lane_mask(dec.dst_w) << BYTE_W) : lane_mask(dec.dst_w);
  assign merged = (dst_word & ~wmask) | ((dec.dst_hi ? (res << BYTE_W) : res) & wmask);

  // Next state
  always_comb begin
    acc_a_nxt     = acc_a_r;
    acc_c_nxt     = acc_c_r;
    acc_d_nxt     = acc_d_r;
    instr_cnt_nxt = instr_cnt_r;
    if (adv) begin
      instr_cnt_nxt = instr_cnt_r + 1'b1;
      if (dec.wr_en) begin
        case (dec.dst_reg)
          2'd0:    acc_a_nxt = merged;
          2'd1:    acc_c_nxt = merged;
          default: acc_d_nxt = merged;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_a_r     <= '0;
      acc_c_r     <= '0;
      acc_d_r     <= '0;
      instr_cnt_r <= '0;
    end else begin
      acc_a_r     <= acc_a_nxt;
      acc_c_r     <= acc_c_nxt;
      acc_d_r     <= acc_d_nxt;
      instr_cnt_r <= instr_cnt_nxt;
    end
  end

  // Show result; the counter is shown after this request's increment
  always_comb begin
    case (dec.show_kind)
      SHOW_REG: show_value = dst_val;
      SHOW_EIP: show_value = instr_cnt_r + 1'b1;
      default:  show_value = imm;
    endcase
  end

  `PRA_ASSERT(a_cnt_step, adv |=> (instr_cnt_r == $past(instr_cnt_r) + 1'b1), "counter did not step on an executed request")
  `PRA_ASSERT(a_idle_hold, !adv |=> ($stable(instr_cnt_r) && $stable(acc_a_r) && $stable(acc_c_r) && $stable(acc_d_r)), "state changed without a request")
  `PRA_ASSERT(a_nowr_hold, (adv && !dec.wr_en) |=> ($stable(acc_a_r) && $stable(acc_c_r) && $stable(acc_d_r)), "accumulator written by a non-writing request")

endmodule

/* hdl/pra_out_stage.sv */
// Output register for show results, decoupling the result channel.
// Depends on pra_pkg.
module pra_out_stage
  import pra_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [DATA_W-1:0] load_data,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic              out_vld_r, out_vld_nxt;
  logic [DATA_W-1:0] data_r;

  // Free, or emptying this cycle
  assign can_load = !out_vld_r || out_ready;

  always_comb begin
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = data_r;

endmodule

/* hdl/partial_register_alu_executor.sv */
// Top level of the partial register ALU executor: input stage, decode,
// execute and output register. Depends on pra_pkg and the pra_* modules.
//
//   Channel | Direction | Ports
//   --------+-----------+-----------------------------------------------------
//   in      | request   | in_valid, in_ready, in_req_type, in_first_operand,
//           |           | in_second_operand, in_imm_value
//   out     | result    | out_valid, out_ready, out_show_value
//
// One request per cycle unless a show request waits on a held result: each
// request is decoded into the input register, then executes against the
// accumulators and counter, with the state update and any show result
// registered at the same edge. A show result is valid once it is loaded
// into the output register when its request executes.
// Reset (synchronous, active low) clears accumulators, counter and valids.
// A held result stalls only a show request waiting in the input register;
// other requests keep flowing until a show request reaches the input register.
module partial_register_alu_executor
  import pra_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_req_type,
  input  logic [3:0]        in_first_operand,
  input  logic [3:0]        in_second_operand,
  input  logic [DATA_W-1:0] in_imm_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_show_value
);

  dec_t              dec_in, dec_r;
  logic [DATA_W-1:0] imm_r;
  logic              stg_vld_r, stg_vld_nxt;
  logic              stg_adv, out_can_load;
  logic [DATA_W-1:0] show_value;

  pra_decode u_decode (
    .req_type       (in_req_type),
    .first_operand  (in_first_operand),
    .second_operand (in_second_operand),
    .dec            (dec_in)
  );

  // Staged request executes unless its result has nowhere to go
  assign stg_adv  = stg_vld_r && (!dec_r.show_en || out_can_load);
  assign in_ready = !stg_vld_r || stg_adv;

  always_comb begin
    if (in_valid && in_ready) begin
      stg_vld_nxt = 1'b1;
    end else if (stg_adv) begin
      stg_vld_nxt = 1'b0;
    end else begin
      stg_vld_nxt = stg_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dec_r <= dec_in;
      imm_r <= in_imm_value;
    end
  end

  pra_exec u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (stg_adv),
    .dec        (dec_r),
    .imm        (imm_r),
    .show_value (show_value)
  );

  pra_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (stg_adv && dec_r.show_en),
    .load_data (show_value),
    .can_load  (out_can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_show_value)
  );

endmodule
